/* rtl/core/hef_pkg.sv */
// hef_pkg: shared constants, payload structs, controller state and command types
// for the hampel/ema sample filter; no dependencies
package hef_pkg;

    localparam int WINDOW     = 70;
    localparam int CHANNELS   = 3;
    localparam int RANK       = WINDOW / 2;
    localparam int MEM_DEPTH  = CHANNELS * WINDOW;
    localparam int ADDR_W     = $clog2(MEM_DEPTH);
    localparam int IDX_W      = $clog2(WINDOW + 1);
    localparam int SAMPLE_W   = 12;
    localparam int ACC_W      = 23;
    localparam int BIT_W      = $clog2(SAMPLE_W);
    localparam int MAX_SHIFT  = 11;
    localparam int SAMPLE_MAX = 4095;

    localparam logic [1:0] REG_SPIKE_MULT = 2'd0;
    localparam logic [1:0] REG_MAD_FLOOR  = 2'd1;
    localparam logic [1:0] REG_FAST_SHIFT = 2'd2;
    localparam logic [1:0] REG_SLOW_SHIFT = 2'd3;

    typedef struct packed {
        logic [1:0]          channel;
        logic [SAMPLE_W-1:0] sample;
    } in_t;

    typedef struct packed {
        logic [1:0]          channel_out;
        logic [SAMPLE_W-1:0] filtered;
        logic [SAMPLE_W-1:0] baseline;
        logic                spike_clipped;
    } out_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_FILL,
        ST_SCAN,
        ST_CLIP,
        ST_RING,
        ST_FAST,
        ST_SLOW,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic             load;
        logic             fill_wr;
        logic             init_ch;
        logic             rd_en;
        logic             cnt_clr;
        logic             cnt_en;
        logic             res_clr;
        logic             bit_done;
        logic             mad_pass;
        logic [BIT_W-1:0] bit_idx;
        logic [IDX_W-1:0] idx;
        logic             clip;
        logic             ring_wr;
        logic             ema_fast;
        logic             ema_slow;
        logic             out_load;
    } cmd_t;

    typedef struct packed {
        logic bypass;
        logic started;
    } sts_t;

    function automatic logic [3:0] eff_shift(logic [3:0] sh);
        return (sh > 4'(MAX_SHIFT)) ? 4'(MAX_SHIFT) : sh;
    endfunction

    function automatic logic [ACC_W-1:0] ema_acc(logic [ACC_W-1:0] acc,
                                                 logic [SAMPLE_W-1:0] xin,
                                                 logic [3:0] sh);
        logic [3:0]              s;
        logic [ACC_W-1:0]        xs;
        logic signed [ACC_W:0]   d;
        logic signed [ACC_W:0]   step;
        logic signed [ACC_W:0]   sum;
        s    = eff_shift(sh);
        xs   = ACC_W'(xin) << s;
        d    = $signed({1'b0, xs}) - $signed({1'b0, acc});
        step = d >>> s;
        sum  = $signed({1'b0, acc}) + step;
        return sum[ACC_W-1:0];
    endfunction

    function automatic logic [SAMPLE_W-1:0] ema_out(logic [ACC_W-1:0] acc, logic [3:0] sh);
        logic [ACC_W-1:0] t;
        t = acc >> eff_shift(sh);
        return (t > ACC_W'(SAMPLE_MAX)) ? SAMPLE_W'(SAMPLE_MAX) : t[SAMPLE_W-1:0];
    endfunction

endpackage

/* rtl/core/hampel_ema_sample_filter_unit.sv */
// hampel_ema_sample_filter_unit: top level, joins controller and datapath
// depends on hef_pkg, hef_ctrl, hef_datapath
//
//   port group  | direction | payload
//   s_*         | in        | hef_pkg::in_t  (channel, sample)
//   m_*         | out       | hef_pkg::out_t (channel_out, filtered, baseline, spike_clipped)
//   cfg_*       | in        | write only, index 0..3, 8-bit data
//
// a filtered sample takes two 12-bit rank searches, each 12 passes over the
// single read port of the window ram, plus clip and ema steps
// the first sample of a channel first fills its window; bypass goes straight to output
// aresetn resets controller state, settings, ring positions and started flags; no ram clearing pass
// one item at a time; a finished result may wait in the output register while the
// next item is taken
module hampel_ema_sample_filter_unit (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  hef_pkg::in_t  s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output hef_pkg::out_t m_data,
    input  logic          cfg_wr_en,
    input  logic [1:0]    cfg_addr,
    input  logic [7:0]    cfg_wdata
);

    hef_pkg::cmd_t cmd;
    hef_pkg::sts_t sts;

    hef_ctrl u_ctrl (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .sts    (sts),
        .cmd    (cmd)
    );

    hef_datapath u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_wr_en(cfg_wr_en),
        .cfg_addr (cfg_addr),
        .cfg_wdata(cfg_wdata),
        .s_data   (s_data),
        .m_data   (m_data),
        .cmd      (cmd),
        .sts      (sts)
    );

endmodule

/* rtl/core/hef_ram.sv */
// hef_ram: generic single write port, single read port ram with registered read
// no dependencies
module hef_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 210
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* rtl/core/hef_ctrl.sv */
// hef_ctrl: sequencer for window fill, bitwise rank search, clip, ema and output
// depends on hef_pkg
module hef_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    output logic          m_valid,
    input  logic          m_ready,
    input  hef_pkg::sts_t sts,
    output hef_pkg::cmd_t cmd
);

    hef_pkg::state_t                state_reg, state_next;
    logic [hef_pkg::IDX_W-1:0]      idx_reg, idx_next;
    logic [hef_pkg::BIT_W-1:0]      bit_reg, bit_next;
    logic                           mad_reg, mad_next;
    logic                           m_valid_reg, m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= hef_pkg::ST_IDLE;
            idx_reg     <= '0;
            bit_reg     <= '0;
            mad_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            bit_reg     <= bit_next;
            mad_reg     <= mad_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        bit_next     = bit_reg;
        mad_next     = mad_reg;
        s_ready      = 1'b0;
        cmd          = '0;
        cmd.idx      = idx_reg;
        cmd.bit_idx  = bit_reg;
        cmd.mad_pass = mad_reg;
        case (state_reg)
            hef_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = hef_pkg::ST_CHECK;
                end
            end
            hef_pkg::ST_CHECK: begin
                idx_next = '0;
                bit_next = hef_pkg::BIT_W'(hef_pkg::SAMPLE_W - 1);
                mad_next = 1'b0;
                if (sts.bypass) begin
                    state_next = hef_pkg::ST_OUT;
                end else if (!sts.started) begin
                    state_next = hef_pkg::ST_FILL;
                end else begin
                    state_next = hef_pkg::ST_SCAN;
                end
            end
            hef_pkg::ST_FILL: begin
                cmd.fill_wr = 1'b1;
                cmd.init_ch = (idx_reg == '0);
                if (idx_reg == hef_pkg::IDX_W'(hef_pkg::WINDOW - 1)) begin
                    idx_next   = '0;
                    state_next = hef_pkg::ST_SCAN;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            hef_pkg::ST_SCAN: begin
                cmd.rd_en   = (idx_reg < hef_pkg::IDX_W'(hef_pkg::WINDOW));
                cmd.cnt_clr = (idx_reg == '0);
                cmd.cnt_en  = (idx_reg != '0);
                cmd.res_clr = (idx_reg == '0) &&
                              (bit_reg == hef_pkg::BIT_W'(hef_pkg::SAMPLE_W - 1));
                if (idx_reg == hef_pkg::IDX_W'(hef_pkg::WINDOW)) begin
                    cmd.bit_done = 1'b1;
                    idx_next     = '0;
                    if (bit_reg == '0) begin
                        if (mad_reg) begin
                            state_next = hef_pkg::ST_CLIP;
                        end else begin
                            mad_next = 1'b1;
                            bit_next = hef_pkg::BIT_W'(hef_pkg::SAMPLE_W - 1);
                        end
                    end else begin
                        bit_next = bit_reg - 1'b1;
                    end
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            hef_pkg::ST_CLIP: begin
                cmd.clip   = 1'b1;
                state_next = hef_pkg::ST_RING;
            end
            hef_pkg::ST_RING: begin
                cmd.ring_wr = 1'b1;
                state_next  = hef_pkg::ST_FAST;
            end
            hef_pkg::ST_FAST: begin
                cmd.ema_fast = 1'b1;
                state_next   = hef_pkg::ST_SLOW;
            end
            hef_pkg::ST_SLOW: begin
                cmd.ema_slow = 1'b1;
                state_next   = hef_pkg::ST_OUT;
            end
            hef_pkg::ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    state_next   = hef_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = hef_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

/* rtl/core/hef_datapath.sv */
// hef_datapath: window ram, rank search counter, clipper, ema accumulators and
// result register; depends on hef_pkg and hef_ram
module hef_datapath (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          cfg_wr_en,
    input  logic [1:0]    cfg_addr,
    input  logic [7:0]    cfg_wdata,
    input  hef_pkg::in_t  s_data,
    output hef_pkg::out_t m_data,
    input  hef_pkg::cmd_t cmd,
    output hef_pkg::sts_t sts
);

    localparam int SW = hef_pkg::SAMPLE_W;

    logic [3:0] mult_reg;
    logic [7:0] floor_reg;
    logic [3:0] fshift_reg;
    logic [3:0] sshift_reg;

    logic [1:0]    ch_reg;
    logic [SW-1:0] raw_reg;
    logic [hef_pkg::CHANNELS-1:0] started_reg;
    logic [hef_pkg::IDX_W-1:0] pos_reg [hef_pkg::CHANNELS];
    logic [hef_pkg::ACC_W-1:0] fast_reg [hef_pkg::CHANNELS];
    logic [hef_pkg::ACC_W-1:0] slow_reg [hef_pkg::CHANNELS];

    logic [SW-1:0]             res_reg, res_next;
    logic [hef_pkg::IDX_W-1:0] cnt_reg, cnt_sum;
    logic [SW-1:0]             median_reg;
    logic [SW-1:0]             x_reg;
    logic                      clip_reg;
    logic [SW-1:0]             y_reg;
    logic [SW-1:0]             b_reg;
    hef_pkg::out_t             out_reg;

    logic                      ch_ok;
    logic [hef_pkg::ADDR_W-1:0] base;
    logic                      we;
    logic [hef_pkg::ADDR_W-1:0] waddr;
    logic [SW-1:0]             wdata;
    logic [hef_pkg::ADDR_W-1:0] raddr;
    logic [SW-1:0]             rdata;
    logic [SW-1:0]             absdiff, val, trial;
    logic                      le;
    logic [SW-1:0]             mad_f;
    logic [15:0]               thr;
    logic signed [17:0]        diff;
    logic [SW-1:0]             x_next;
    logic                      clip_next;
    logic [hef_pkg::ACC_W-1:0] fast_new, slow_new;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mult_reg   <= 4'd5;
            floor_reg  <= 8'd2;
            fshift_reg <= 4'd9;
            sshift_reg <= 4'd11;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                hef_pkg::REG_SPIKE_MULT: mult_reg   <= cfg_wdata[3:0];
                hef_pkg::REG_MAD_FLOOR:  floor_reg  <= cfg_wdata;
                hef_pkg::REG_FAST_SHIFT: fshift_reg <= cfg_wdata[3:0];
                hef_pkg::REG_SLOW_SHIFT: sshift_reg <= cfg_wdata[3:0];
                default: ;
            endcase
        end
    end

    assign ch_ok       = (ch_reg < 2'(hef_pkg::CHANNELS));
    assign sts.bypass  = !ch_ok;
    assign sts.started = ch_ok ? started_reg[ch_reg] : 1'b1;
    assign base        = hef_pkg::ADDR_W'(ch_reg) * hef_pkg::ADDR_W'(hef_pkg::WINDOW);

    assign we    = cmd.fill_wr || cmd.ring_wr;
    assign waddr = base + hef_pkg::ADDR_W'(cmd.fill_wr ? cmd.idx : pos_reg[ch_reg]);
    assign wdata = cmd.fill_wr ? raw_reg : x_reg;
    assign raddr = base + hef_pkg::ADDR_W'(cmd.idx);

    hef_ram #(
        .WIDTH(hef_pkg::SAMPLE_W),
        .DEPTH(hef_pkg::MEM_DEPTH)
    ) u_window (
        .aclk (aclk),
        .we   (we),
        .waddr(waddr),
        .wdata(wdata),
        .re   (cmd.rd_en),
        .raddr(raddr),
        .rdata(rdata)
    );

    // bitwise search for the smallest value with more than RANK entries at or below it
    assign absdiff = (rdata >= median_reg) ? (rdata - median_reg) : (median_reg - rdata);
    assign val     = cmd.mad_pass ? absdiff : rdata;
    assign trial   = res_reg | ((SW'(1) << cmd.bit_idx) - SW'(1));
    assign le      = (val <= trial);
    assign cnt_sum = (cmd.cnt_clr ? '0 : cnt_reg) +
                     hef_pkg::IDX_W'(cmd.cnt_en && le);

    always_comb begin
        res_next = res_reg;
        if (cmd.res_clr) begin
            res_next = '0;
        end else if (cmd.bit_done) begin
            res_next[cmd.bit_idx] = !(cnt_sum > hef_pkg::IDX_W'(hef_pkg::RANK));
        end
    end

    // clip to median +/- mad * multiplier
    always_comb begin
        mad_f     = (res_reg < SW'(floor_reg)) ? SW'(floor_reg) : res_reg;
        thr       = 16'(mad_f) * 16'(mult_reg);
        diff      = $signed(18'(raw_reg)) - $signed(18'(median_reg));
        x_next    = raw_reg;
        clip_next = 1'b0;
        if (mad_f != '0) begin
            if (diff > $signed(18'(thr))) begin
                x_next    = SW'(18'(median_reg) + 18'(thr));
                clip_next = 1'b1;
            end else if (diff < -$signed(18'(thr))) begin
                x_next    = SW'(18'(median_reg) - 18'(thr));
                clip_next = 1'b1;
            end
        end
    end

    assign fast_new = hef_pkg::ema_acc(fast_reg[ch_reg], x_reg, fshift_reg);
    assign slow_new = hef_pkg::ema_acc(slow_reg[ch_reg], y_reg, sshift_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            started_reg <= '0;
            for (int i = 0; i < hef_pkg::CHANNELS; i++) begin
                pos_reg[i] <= '0;
            end
        end else begin
            if (cmd.init_ch) begin
                started_reg[ch_reg] <= 1'b1;
            end
            if (cmd.ring_wr) begin
                pos_reg[ch_reg] <=
                    (pos_reg[ch_reg] == hef_pkg::IDX_W'(hef_pkg::WINDOW - 1)) ?
                    '0 : pos_reg[ch_reg] + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            ch_reg  <= s_data.channel;
            raw_reg <= s_data.sample;
        end
        res_reg <= res_next;
        cnt_reg <= cnt_sum;
        if (cmd.bit_done && !cmd.mad_pass && cmd.bit_idx == '0) begin
            median_reg <= res_next;
        end
        if (cmd.clip) begin
            x_reg    <= x_next;
            clip_reg <= clip_next;
        end
        if (cmd.init_ch) begin
            fast_reg[ch_reg] <= hef_pkg::ACC_W'(raw_reg) << hef_pkg::eff_shift(fshift_reg);
            slow_reg[ch_reg] <= hef_pkg::ACC_W'(raw_reg) << hef_pkg::eff_shift(sshift_reg);
        end
        if (cmd.ema_fast) begin
            fast_reg[ch_reg] <= fast_new;
            y_reg            <= hef_pkg::ema_out(fast_new, fshift_reg);
        end
        if (cmd.ema_slow) begin
            slow_reg[ch_reg] <= slow_new;
            b_reg            <= hef_pkg::ema_out(slow_new, sshift_reg);
        end
        if (cmd.out_load) begin
            out_reg.channel_out <= ch_reg;
            if (ch_ok) begin
                out_reg.filtered      <= y_reg;
                out_reg.baseline      <= b_reg;
                out_reg.spike_clipped <= clip_reg;
            end else begin
                out_reg.filtered      <= raw_reg;
                out_reg.baseline      <= '0;
                out_reg.spike_clipped <= 1'b0;
            end
        end
    end

    assign m_data = out_reg;

endmodule

/* rtl/core/hef_checker.sv */
// hef_checker: port-level assertions for the filter unit, bound to the top level
// depends on hef_pkg and hampel_ema_sample_filter_unit
module hef_checker (
    input logic          aclk,
    input logic          aresetn,
    input logic          s_valid,
    input logic          s_ready,
    input logic          m_valid,
    input logic          m_ready,
    input hef_pkg::out_t m_data
);

    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_valid && s_ready)
        else $error("not idle after reset");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second transfer taken while busy");

    a_hold_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result changed");

    a_bypass_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.channel_out == 2'(hef_pkg::CHANNELS) |->
        m_data.baseline == '0 && !m_data.spike_clipped)
        else $error("bypass result not clean");

endmodule

bind hampel_ema_sample_filter_unit hef_checker u_hef_checker (
    .aclk   (aclk),
    .aresetn(aresetn),
    .s_valid(s_valid),
    .s_ready(s_ready),
    .m_valid(m_valid),
    .m_ready(m_ready),
    .m_data (m_data)
);

/* verif/tb_hampel_ema_sample_filter_unit.sv */
// tb_hampel_ema_sample_filter_unit: self-checking bench for the hampel/ema sample filter
// predicts every result from its own per-channel window and ema state, checks field by field
// depends on hef_pkg and hampel_ema_sample_filter_unit
module tb_hampel_ema_sample_filter_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  PHASES      = 8;
    localparam int  RAND_ITEMS  = 140;
    localparam int  SETTLE      = 40;
    localparam longint CYCLE_LIMIT = 20_000_000;

    logic           aclk = 1'b0;
    logic           aresetn = 1'b0;
    logic           s_valid = 1'b0;
    logic           s_ready;
    hef_pkg::in_t   s_data = '0;
    logic           m_valid;
    logic           m_ready = 1'b0;
    hef_pkg::out_t  m_data;
    logic           cfg_wr_en = 1'b0;
    logic [1:0]     cfg_addr = '0;
    logic [7:0]     cfg_wdata = '0;

    hampel_ema_sample_filter_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
    );

    always #6 aclk = ~aclk;

    // filter configuration as seen by the predictor
    int unsigned clip_mult, mad_min, fast_sh, slow_sh;

    // per-channel filter state
    int          win [hef_pkg::CHANNELS][hef_pkg::WINDOW];
    int          ring_pos [hef_pkg::CHANNELS];
    longint      fast_acc [hef_pkg::CHANNELS];
    longint      slow_acc [hef_pkg::CHANNELS];
    bit          started [hef_pkg::CHANNELS];

    hef_pkg::in_t  pending_samples [$];
    hef_pkg::out_t expected_results [$];

    int          errors = 0;
    int          accepted = 0;
    int          delivered = 0;
    int          clip_count = 0;
    int          bypass_count = 0;
    longint      cycles = 0;

    int          src_gap = 0;
    int          sink_stall = 0;
    bit          src_quiet = 0;
    bit          sink_quiet = 0;

    function automatic void sort_window(ref int v[hef_pkg::WINDOW]);
        int key;
        int j;
        for (int i = 1; i < hef_pkg::WINDOW; i++) begin
            key = v[i];
            j = i - 1;
            while (j >= 0 && v[j] > key) begin
                v[j + 1] = v[j];
                j--;
            end
            v[j + 1] = key;
        end
    endfunction

    function automatic longint ema_advance(inout longint acc, input longint x,
                                           input int unsigned s);
        longint y;
        acc = acc + (((x <<< s) - acc) >>> s);
        y = acc >>> s;
        return (y > hef_pkg::SAMPLE_MAX) ? hef_pkg::SAMPLE_MAX : y;
    endfunction

    function automatic hef_pkg::out_t filter_predict(hef_pkg::in_t item);
        hef_pkg::out_t r;
        int          t [hef_pkg::WINDOW];
        int          ch;
        int          raw, med, mad, thr, diff, x;
        int unsigned sf, ss;
        longint      y, b;
        r = '0;
        r.channel_out = item.channel;
        ch = item.channel;
        raw = item.sample;
        if (ch >= hef_pkg::CHANNELS) begin
            r.filtered = item.sample;
            return r;
        end
        sf = (fast_sh > hef_pkg::MAX_SHIFT) ? hef_pkg::MAX_SHIFT : fast_sh;
        ss = (slow_sh > hef_pkg::MAX_SHIFT) ? hef_pkg::MAX_SHIFT : slow_sh;
        if (!started[ch]) begin
            for (int i = 0; i < hef_pkg::WINDOW; i++) win[ch][i] = raw;
            fast_acc[ch] = longint'(raw) <<< sf;
            slow_acc[ch] = longint'(raw) <<< ss;
            started[ch] = 1'b1;
        end
        for (int i = 0; i < hef_pkg::WINDOW; i++) t[i] = win[ch][i];
        sort_window(t);
        med = t[hef_pkg::WINDOW / 2];
        for (int i = 0; i < hef_pkg::WINDOW; i++)
            t[i] = (win[ch][i] >= med) ? win[ch][i] - med : med - win[ch][i];
        sort_window(t);
        mad = t[hef_pkg::WINDOW / 2];
        if (mad < int'(mad_min)) mad = int'(mad_min);
        x = raw;
        if (mad > 0) begin
            thr = mad * int'(clip_mult);
            diff = raw - med;
            if (diff > thr) begin
                x = med + thr;
                r.spike_clipped = 1'b1;
            end else if (diff < -thr) begin
                x = med - thr;
                r.spike_clipped = 1'b1;
            end
        end
        win[ch][ring_pos[ch]] = x;
        ring_pos[ch] = (ring_pos[ch] + 1) % hef_pkg::WINDOW;
        y = ema_advance(fast_acc[ch], x, sf);
        b = ema_advance(slow_acc[ch], y, ss);
        r.filtered = y[hef_pkg::SAMPLE_W-1:0];
        r.baseline = b[hef_pkg::SAMPLE_W-1:0];
        return r;
    endfunction

    // source side
    always @(posedge aclk) begin
        int            g;
        hef_pkg::in_t  nxt;
        if (!aresetn) begin
            s_valid <= 1'b0;
            src_gap <= 0;
        end else begin
            if ($urandom_range(0, 59) == 0) src_quiet <= ~src_quiet;
            if (s_valid && s_ready) begin
                expected_results.push_back(filter_predict(s_data));
                accepted++;
                g = src_quiet ? 0 : $urandom_range(0, 7);
                if (g == 0 && pending_samples.size() != 0) begin
                    nxt = pending_samples.pop_front();
                    s_data <= nxt;
                end else begin
                    s_valid <= 1'b0;
                    src_gap <= g;
                end
            end else if (!s_valid) begin
                if (src_gap > 0) begin
                    src_gap <= src_gap - 1;
                end else if (pending_samples.size() != 0) begin
                    nxt = pending_samples.pop_front();
                    s_data <= nxt;
                    s_valid <= 1'b1;
                end
            end
        end
    end

    // result side
    always @(posedge aclk) begin
        int            st;
        hef_pkg::out_t e;
        if (!aresetn) begin
            m_ready <= 1'b0;
            sink_stall <= 0;
        end else begin
            if ($urandom_range(0, 59) == 0) sink_quiet <= ~sink_quiet;
            if (m_valid && m_ready) begin
                delivered++;
                if (expected_results.size() == 0) begin
                    $error("result transfer with nothing expected: %p", m_data);
                    errors++;
                end else begin
                    e = expected_results.pop_front();
                    if (m_data.channel_out !== e.channel_out) begin
                        $error("channel_out expected %0d got %0d", e.channel_out,
                               m_data.channel_out);
                        errors++;
                    end
                    if (m_data.filtered !== e.filtered) begin
                        $error("filtered expected %0d got %0d", e.filtered, m_data.filtered);
                        errors++;
                    end
                    if (m_data.baseline !== e.baseline) begin
                        $error("baseline expected %0d got %0d", e.baseline, m_data.baseline);
                        errors++;
                    end
                    if (m_data.spike_clipped !== e.spike_clipped) begin
                        $error("spike_clipped expected %0d got %0d", e.spike_clipped,
                               m_data.spike_clipped);
                        errors++;
                    end
                    if (e.spike_clipped) clip_count++;
                    if (e.channel_out >= hef_pkg::CHANNELS) bypass_count++;
                end
                st = sink_quiet ? 0 : $urandom_range(0, 7);
                sink_stall <= st;
                m_ready <= (st == 0);
            end else if (!m_ready) begin
                if (sink_stall <= 1) m_ready <= 1'b1;
                if (sink_stall > 0) sink_stall <= sink_stall - 1;
            end
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles,
                     expected_results.size());
            $display("tb_hampel_ema_sample_filter_unit NOT OK");
            $finish;
        end
    end

    task automatic push_sample(int ch, int smp);
        hef_pkg::in_t it;
        it.channel = ch[1:0];
        it.sample = smp[hef_pkg::SAMPLE_W-1:0];
        pending_samples.push_back(it);
    endtask

    task automatic wait_drained();
        while (pending_samples.size() != 0 || s_valid || expected_results.size() != 0)
            @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_settings(int unsigned mult, int unsigned floor_v,
                                  int unsigned fsh, int unsigned ssh);
        logic [1:0] idx [4];
        int unsigned val [4];
        idx = '{hef_pkg::REG_SPIKE_MULT, hef_pkg::REG_MAD_FLOOR,
                hef_pkg::REG_FAST_SHIFT, hef_pkg::REG_SLOW_SHIFT};
        val = '{mult, floor_v, fsh, ssh};
        for (int i = 0; i < 4; i++) begin
            @(posedge aclk);
            cfg_wr_en <= 1'b1;
            cfg_addr <= idx[i];
            cfg_wdata <= val[i][7:0];
        end
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        clip_mult = mult & 4'hf;
        mad_min = floor_v & 8'hff;
        fast_sh = fsh & 4'hf;
        slow_sh = ssh & 4'hf;
    endtask

    task automatic queue_random(int n);
        int level [hef_pkg::CHANNELS];
        int ch, smp, nz;
        for (int c = 0; c < hef_pkg::CHANNELS; c++) level[c] = $urandom_range(0, 4095);
        for (int i = 0; i < n; i++) begin
            ch = ($urandom_range(0, 99) < 10) ? 3 : $urandom_range(0, hef_pkg::CHANNELS - 1);
            if (ch >= hef_pkg::CHANNELS || $urandom_range(0, 99) < 15) begin
                smp = $urandom_range(0, 4095);
            end else begin
                level[ch] += int'($urandom_range(0, 40)) - 20;
                if (level[ch] < 0) level[ch] = 0;
                if (level[ch] > 4095) level[ch] = 4095;
                nz = $urandom_range(0, 12);
                smp = level[ch] + int'($urandom_range(0, 2 * nz)) - nz;
                if (smp < 0) smp = 0;
                if (smp > 4095) smp = 4095;
            end
            push_sample(ch, smp);
        end
    endtask

    initial begin
        int unsigned pm [PHASES];
        int unsigned pf [PHASES];
        int unsigned pfs [PHASES];
        int unsigned pss [PHASES];
        pm  = '{5, 5, 0, 15, 1, 3, 0, 7};
        pf  = '{2, 0, 2, 255, 1, 8, 0, 40};
        pfs = '{9, 9, 0, 15, 1, 11, 0, 4};
        pss = '{11, 11, 0, 12, 1, 6, 0, 8};
        clip_mult = 5;
        mad_min = 2;
        fast_sh = 9;
        slow_sh = 11;
        for (int c = 0; c < hef_pkg::CHANNELS; c++) begin
            ring_pos[c] = 0;
            started[c] = 1'b0;
            fast_acc[c] = 0;
            slow_acc[c] = 0;
        end
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // first samples at the extremes, spikes both ways, bypass
        push_sample(0, 2000);
        push_sample(0, 4095);
        push_sample(0, 0);
        push_sample(0, 2001);
        push_sample(1, 4095);
        push_sample(1, 0);
        push_sample(2, 0);
        push_sample(2, 4095);
        push_sample(3, 4095);
        push_sample(3, 0);
        push_sample(3, 2730);

        for (int p = 0; p < PHASES; p++) begin
            if (p == 6) begin
                pm[p] = $urandom_range(0, 15);
                pf[p] = $urandom_range(0, 255);
                pfs[p] = $urandom_range(0, 15);
                pss[p] = $urandom_range(0, 15);
            end
            if (p != 0) begin
                wait_drained();
                write_settings(pm[p], pf[p], pfs[p], pss[p]);
            end
            // zero mad with no floor, then zero multiplier
            if (p == 1) push_sample(0, 4095);
            if (p == 2) push_sample(1, 100);
            queue_random(RAND_ITEMS);
        end
        wait_drained();

        $display("%0d samples, %0d results: %0d clipped, %0d bypassed, %0d settings phases",
                 accepted, delivered, clip_count, bypass_count, PHASES);
        if (errors == 0) begin
            $display("tb_hampel_ema_sample_filter_unit OK");
        end else begin
            $display("%0d mismatches", errors);
            $display("tb_hampel_ema_sample_filter_unit NOT OK");
        end
        $finish;
    end

endmodule
